// File: hw/rtl/vdfc_pkg.sv
// Package for the variable delay feedback comb: sizes, types, the sequencer
// states and the saturation helper. No dependencies.
package vdfc_pkg;

  localparam int unsigned DEPTH     = 65536;
  localparam int unsigned ADDR_W    = $clog2(DEPTH);
  localparam int unsigned SAMPLE_W  = 24;
  localparam int unsigned DELAY_W   = 24;
  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned SPM_W     = 16;
  localparam int unsigned GAIN_FRAC = 14;
  localparam int unsigned CNT_FRAC  = 16;

  localparam int unsigned MUL_A_W   = 25;
  localparam int unsigned MUL_B_W   = 17;
  localparam int unsigned PROD_W    = MUL_A_W + MUL_B_W;
  localparam int unsigned CNT_W     = PROD_W - 2 - CNT_FRAC;
  localparam int unsigned SUM_W     = PROD_W + 1;
  localparam int unsigned FLOOR_W   = SUM_W - GAIN_FRAC;

  localparam logic [SPM_W-1:0] SPM_RESET = SPM_W'(12288);

  typedef logic [ADDR_W-1:0]          addr_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic    rd_en;
    addr_t   rd_addr;
    logic    wr_en;
    addr_t   wr_addr;
    sample_t wr_data;
  } ring_req_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ADDR  = 4'b0010,
    S_MUL_G = 4'b0100,
    S_WRITE = 4'b1000
  } state_e;

  function automatic sample_t sat_sample(input logic signed [FLOOR_W-1:0] v);
    logic signed [FLOOR_W-1:0] hi;
    logic signed [FLOOR_W-1:0] lo;
    hi = FLOOR_W'((64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1);
    lo = -hi - FLOOR_W'(1);
    if (v > hi) begin
      return sample_t'(hi);
    end else if (v < lo) begin
      return sample_t'(lo);
    end else begin
      return sample_t'(v);
    end
  endfunction

endpackage

// File: hw/rtl/vdfc_ring.sv
// Delay ring storage of the variable delay feedback comb: one write port and
// one registered read port. Depends on vdfc_pkg.
module vdfc_ring (
  input  logic                clk_i,
  input  vdfc_pkg::ring_req_t req_i,
  output vdfc_pkg::sample_t   rdata_o
);
  import vdfc_pkg::*;

  sample_t mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rdata_o <= mem[req_i.rd_addr];
    end
  end

endmodule

// File: hw/rtl/variable_delay_feedback_comb_core.sv
// Top level of the variable delay feedback comb: sequencer, shared multiplier
// and output register. Depends on vdfc_pkg and vdfc_ring.
// Sequence: an input transfer steps through S_ADDR, S_MUL_G and S_WRITE, and the result
// is registered on the ring write; no new item is taken before that, the one multiplier
// serving delay scaling and feedback product in turn; a stalled result holds the write.
// Reset: control state clears at once; a wrap flag makes unwritten entries read as zero.
module variable_delay_feedback_comb_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [vdfc_pkg::SAMPLE_W-1:0] in_sample_i,
  input  logic signed [vdfc_pkg::DELAY_W-1:0]  delay_ms_i,
  input  logic signed [vdfc_pkg::GAIN_W-1:0]   feedback_gain_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [vdfc_pkg::SAMPLE_W-1:0] delayed_sample_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [vdfc_pkg::SPM_W-1:0]          cfg_data_i
);
  import vdfc_pkg::*;

  state_e state_q, state_d;
  logic [SPM_W-1:0] spm_q;
  addr_t wp_q;
  logic wrapped_q;
  logic rd_ok_q;
  sample_t x_q;
  logic signed [GAIN_W-1:0] g_q;
  sample_t y_q;
  logic signed [PROD_W-1:0] prod_q;
  logic out_valid_q;
  sample_t delayed_sample_q;

  logic in_xfer;
  logic out_free;
  logic do_write;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic [CNT_W-1:0] cnt_raw;
  logic [ADDR_W:0] cnt_clamped;
  addr_t rd_addr;
  sample_t ring_rdata;
  sample_t y_sel;
  logic signed [SUM_W-1:0] fb_sum;
  logic signed [FLOOR_W-1:0] fb_floor;
  ring_req_t ring_req;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign do_write    = (state_q == S_WRITE) && out_free;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o      = out_valid_q;
  assign delayed_sample_o = delayed_sample_q;

  // The one multiplier scales the delay on transfer and forms the feedback later.
  always_comb begin
    if (state_q == S_MUL_G) begin
      mul_a = MUL_A_W'(y_sel);
      mul_b = MUL_B_W'(g_q);
    end else begin
      mul_a = MUL_A_W'(delay_ms_i);
      mul_b = $signed({1'b0, spm_q});
    end
    mul_p = mul_a * mul_b;
  end

  always_comb begin
    cnt_raw = prod_q[CNT_FRAC +: CNT_W];
    if (prod_q[PROD_W-1]) begin
      cnt_clamped = '0;
    end else if (cnt_raw > CNT_W'(DEPTH)) begin
      cnt_clamped = (ADDR_W+1)'(DEPTH - 1);
    end else begin
      cnt_clamped = cnt_raw[ADDR_W:0];
    end
    rd_addr = wp_q - cnt_clamped[ADDR_W-1:0];
  end

  assign y_sel    = rd_ok_q ? ring_rdata : '0;
  assign fb_sum   = (SUM_W'(x_q) <<< GAIN_FRAC) + SUM_W'(prod_q);
  assign fb_floor = FLOOR_W'(fb_sum >>> GAIN_FRAC);

  always_comb begin
    ring_req.rd_en   = (state_q == S_ADDR);
    ring_req.rd_addr = rd_addr;
    ring_req.wr_en   = do_write;
    ring_req.wr_addr = wp_q;
    ring_req.wr_data = sat_sample(fb_floor);
  end

  vdfc_ring u_ring (
    .clk_i   (clk_i),
    .req_i   (ring_req),
    .rdata_o (ring_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_ADDR;
        end
      end
      S_ADDR: begin
        state_d = S_MUL_G;
      end
      S_MUL_G: begin
        state_d = S_WRITE;
      end
      S_WRITE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      spm_q       <= SPM_RESET;
      wp_q        <= '0;
      wrapped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        spm_q <= cfg_data_i;
      end
      if (do_write) begin
        wp_q <= wp_q + addr_t'(1);
        if (wp_q == addr_t'(DEPTH - 1)) begin
          wrapped_q <= 1'b1;
        end
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      x_q <= in_sample_i;
      g_q <= feedback_gain_i;
    end
    if (in_xfer || state_q == S_MUL_G) begin
      prod_q <= mul_p;
    end
    if (state_q == S_ADDR) begin
      rd_ok_q <= wrapped_q || (rd_addr < wp_q);
    end
    if (state_q == S_MUL_G) begin
      y_q <= y_sel;
    end
    if (do_write) begin
      delayed_sample_q <= y_q;
    end
  end

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("Sequencer state is not one-hot.");

  a_xfer_to_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == S_ADDR) ##1 (state_q == S_MUL_G) ##1 (state_q == S_WRITE))
    else $error("Sequencer did not step through the item after a transfer.");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_write |=> out_valid_o && (wp_q == $past(wp_q) + addr_t'(1)))
    else $error("Ring write did not load the result and advance the pointer.");

  a_wrap_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(wrapped_q))
    else $error("Wrap flag cleared outside reset.");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for variable_delay_feedback_comb_core: a delay line model
// predicts every delayed sample and is checked against each output transfer.
// Depends on vdfc_pkg and the core RTL only.
module testbench;
  import vdfc_pkg::*;

  localparam longint RING_DEPTH   = longint'(DEPTH);
  localparam longint DELAY_MAX    = (longint'(1) <<< (DELAY_W - 1)) - 1;
  localparam longint SAT_HI       = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
  localparam longint SAT_LO       = -SAT_HI - 1;
  localparam int     RANDOM_ITEMS = 90;
  localparam int     FINAL_ITEMS  = 80;
  localparam int     CYCLE_LIMIT  = 2_000_000;

  localparam logic signed [SAMPLE_W-1:0] X_MAX = {1'b0, {(SAMPLE_W - 1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] X_MIN = {1'b1, {(SAMPLE_W - 1){1'b0}}};
  localparam logic signed [DELAY_W-1:0]  D_MAX = {1'b0, {(DELAY_W - 1){1'b1}}};
  localparam logic signed [DELAY_W-1:0]  D_MIN = {1'b1, {(DELAY_W - 1){1'b0}}};
  localparam logic signed [GAIN_W-1:0]   G_MAX = {1'b0, {(GAIN_W - 1){1'b1}}};
  localparam logic signed [GAIN_W-1:0]   G_MIN = {1'b1, {(GAIN_W - 1){1'b0}}};

  class comb_echo_tracker;
    bit signed [SAMPLE_W-1:0] ring_mem [DEPTH];
    int unsigned              wr_ptr;
    bit [SPM_W-1:0]           spm;
    bit signed [SAMPLE_W-1:0] echo_q [$];
    int                       fail_count;
    int                       checked;
    int                       neg_clamps;
    int                       deep_clamps;
    int                       oldest_reads;
    int                       sat_writes;
    int                       wraps;

    function new();
      spm = SPM_RESET;
    endfunction

    function void flag(string msg);
      fail_count++;
      $display("%s", msg);
    endfunction

    function void note_input(logic signed [SAMPLE_W-1:0] x, logic signed [DELAY_W-1:0] d,
                             logic signed [GAIN_W-1:0] g);
      longint                   prod;
      longint                   cnt;
      longint                   rd;
      longint                   sum;
      longint                   wr_val;
      bit signed [SAMPLE_W-1:0] y;
      prod = longint'(d) * longint'(spm);
      if (prod < 0) begin
        cnt = 0;
        neg_clamps++;
      end else begin
        cnt = prod >>> CNT_FRAC;
      end
      if (cnt > RING_DEPTH) begin
        cnt = RING_DEPTH - 1;
        deep_clamps++;
      end else if (cnt == RING_DEPTH) begin
        oldest_reads++;
      end
      rd = (longint'(wr_ptr) + RING_DEPTH - cnt) % RING_DEPTH;
      y = ring_mem[rd];
      sum = (longint'(x) <<< GAIN_FRAC) + longint'(y) * longint'(g);
      wr_val = sum >>> GAIN_FRAC;
      if (wr_val > SAT_HI) begin
        wr_val = SAT_HI;
        sat_writes++;
      end else if (wr_val < SAT_LO) begin
        wr_val = SAT_LO;
        sat_writes++;
      end
      ring_mem[wr_ptr] = wr_val[SAMPLE_W-1:0];
      wr_ptr = (wr_ptr + 1) % DEPTH;
      if (wr_ptr == 0) begin
        wraps++;
      end
      echo_q.push_back(y);
    endfunction

    function void check_echo(logic signed [SAMPLE_W-1:0] actual);
      bit signed [SAMPLE_W-1:0] expected;
      checked++;
      if (echo_q.size() == 0) begin
        flag($sformatf("%0t: delayed sample expected none, actual %0d (transfer %0d)",
                       $time, actual, checked));
        return;
      end
      expected = echo_q.pop_front();
      if (actual !== expected) begin
        flag($sformatf("%0t: delayed sample expected %0d, actual %0d (transfer %0d)",
                       $time, expected, actual, checked));
      end
    endfunction
  endclass

  logic                        clk_i            = 1'b0;
  logic                        rst_ni           = 1'b0;
  logic                        in_valid_i       = 1'b0;
  logic                        in_stall_o;
  logic signed [SAMPLE_W-1:0]  in_sample_i      = '0;
  logic signed [DELAY_W-1:0]   delay_ms_i       = '0;
  logic signed [GAIN_W-1:0]    feedback_gain_i  = '0;
  logic                        out_valid_o;
  logic                        out_stall_i      = 1'b0;
  logic signed [SAMPLE_W-1:0]  delayed_sample_o;
  logic                        cfg_valid_i      = 1'b0;
  logic                        cfg_ready_o;
  logic [SPM_W-1:0]            cfg_data_i       = '0;

  comb_echo_tracker tracker;
  int unsigned      send_idle_pct = 8;
  int unsigned      stall_pct     = 8;
  int               spm_writes    = 0;
  int               cycle_count;

  variable_delay_feedback_comb_core u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_sample_i      (in_sample_i),
    .delay_ms_i       (delay_ms_i),
    .feedback_gain_i  (feedback_gain_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .delayed_sample_o (delayed_sample_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      tracker.check_echo(delayed_sample_o);
    end
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  task automatic send_item(input logic signed [SAMPLE_W-1:0] x,
                           input logic signed [DELAY_W-1:0] d,
                           input logic signed [GAIN_W-1:0] g);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    in_sample_i     <= x;
    delay_ms_i      <= d;
    feedback_gain_i <= g;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.note_input(x, d, g);
  endtask

  function automatic logic signed [DELAY_W-1:0] delay_for_count(longint cnt);
    longint s;
    longint v;
    s = longint'(tracker.spm);
    if (s == 0) begin
      return DELAY_W'($urandom);
    end
    v = ((cnt <<< CNT_FRAC) + s - 1) / s;
    if (v > DELAY_MAX) begin
      v = DELAY_MAX;
    end
    return v[DELAY_W-1:0];
  endfunction

  task automatic send_random();
    int unsigned                 pick;
    logic signed [SAMPLE_W-1:0]  x;
    logic signed [DELAY_W-1:0]   d;
    logic signed [GAIN_W-1:0]    g;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      d = delay_for_count($urandom_range(0, 64));
    end else if (pick < 70) begin
      d = delay_for_count($urandom_range(65, 3000));
    end else if (pick < 78) begin
      d = delay_for_count(RING_DEPTH - 1 + $urandom_range(0, 2));
    end else if (pick < 88) begin
      d = DELAY_W'(32'd0 - $urandom_range(1, 32'd8388608));
    end else begin
      d = DELAY_W'($urandom);
    end
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 3))
        0: x = X_MAX;
        1: x = X_MIN;
        2: x = '0;
        default: x = -24'sd1;
      endcase
    end else begin
      x = SAMPLE_W'($urandom);
    end
    if ($urandom_range(0, 9) < 3) begin
      case ($urandom_range(0, 4))
        0: g = G_MAX;
        1: g = G_MIN;
        2: g = 16'sd16384;
        3: g = -16'sd16384;
        default: g = '0;
      endcase
    end else begin
      g = GAIN_W'($urandom);
    end
    send_item(x, d, g);
  endtask

  task automatic write_spm(input logic [SPM_W-1:0] value);
    while (tracker.echo_q.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    tracker.spm = value;
    spm_writes++;
  endtask

  task automatic run_phase(input logic [SPM_W-1:0] spm_value, input int unsigned idle_pct,
                           input int unsigned hold_pct, input int items);
    in_valid_i <= 1'b0;
    write_spm(spm_value);
    send_idle_pct = idle_pct;
    stall_pct     = hold_pct;
    repeat (items) send_random();
  endtask

  task automatic run_directed();
    send_item(X_MAX, '0, '0);
    send_item(X_MIN, '0, G_MAX);
    send_item('0, -24'sd1, G_MIN);
    send_item(-24'sd1, D_MIN, -16'sd1);
    send_item(X_MAX, delay_for_count(4), G_MAX);
    send_item(X_MIN, delay_for_count(4), G_MAX);
    send_item(24'sd5, delay_for_count(3), 16'sd1);
    send_item(-24'sd3, delay_for_count(3), G_MIN);
    send_item('0, delay_for_count(2), -16'sd1);
    send_item('0, delay_for_count(RING_DEPTH), G_MAX);
    send_item(X_MAX, delay_for_count(RING_DEPTH + 1), G_MAX);
    send_item(X_MIN, D_MAX, G_MIN);
    send_item(24'sd1, delay_for_count(1), 16'sd16384);
    send_item(-24'sd1, '0, G_MAX);
    send_item(24'sd7, 24'sd1, G_MAX);
    send_item(24'sd123456, delay_for_count(1), -16'sd16384);
    send_item(-24'sd99, delay_for_count(14), G_MAX);
    send_item(X_MAX, delay_for_count(16), G_MIN);
  endtask

  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk_i);
    $display("Run stopped at the cycle limit with transfers outstanding.");
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    tracker = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    run_phase(16'hFFFF, 0, 0, RANDOM_ITEMS);
    run_phase(16'h0000, 80, 0, RANDOM_ITEMS);
    run_phase(16'h0100, 0, 80, RANDOM_ITEMS);
    run_phase(SPM_W'($urandom_range(1, 65534)), 8, 8, RANDOM_ITEMS);
    run_phase(SPM_RESET, 80, 80, RANDOM_ITEMS);
    run_phase(16'hFFFF, 0, 0, FINAL_ITEMS);
    in_valid_i <= 1'b0;
    while (tracker.echo_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    $display("Checked %0d output transfers across %0d rate settings and several idle mixes.",
             tracker.checked, spm_writes + 1);
    $display("Seen %0d negative delays, %0d over-depth delays, %0d full-depth reads, %0d %s",
             tracker.neg_clamps, tracker.deep_clamps, tracker.oldest_reads,
             tracker.sat_writes, "saturated writes.");
    if (tracker.fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/vdfc_pkg.sv
hw/rtl/vdfc_ring.sv
hw/rtl/variable_delay_feedback_comb_core.sv
tb/sv/testbench.sv
